// File: rtl/core/jrd_pkg.sv
// ----------------------------------------------------------------------------
// jrd_pkg
// Shared types, constants and the CRC-32 byte step for the journal record
// deframer.
// ----------------------------------------------------------------------------
`default_nettype none

package jrd_pkg;

    // Offset counter width (file positions wrap modulo 2^OFFSET_BITS)
    localparam int OFFSET_BITS = 40;
    localparam int OUT_OFF_BITS = 40;

    // Header layout (byte positions inside the 24-byte header)
    localparam logic [4:0] HC_MAGIC_END   = 5'd4;
    localparam logic [4:0] HC_VERSION_END = 5'd7;
    localparam logic [4:0] HC_SEQ_END     = 5'd15;
    localparam logic [4:0] HC_LEN_END     = 5'd19;
    localparam logic [4:0] HC_CRC_END     = 5'd23;

    // CRC-32, reflected
    localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
    localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;

    // Result kinds
    localparam logic KIND_RECORD  = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    // Result queue
    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = $clog2(Q_DEPTH);

    typedef logic [OFFSET_BITS-1:0] t_offset;

    typedef struct packed {
        logic                    kind;
        logic [63:0]             record_sequence;
        logic [31:0]             payload_length;
        logic [OUT_OFF_BITS-1:0] record_offset;
        logic [OUT_OFF_BITS-1:0] valid_bytes;
        logic                    tail_discarded;
        logic                    last_of_run;
    } t_result;

    // Up to two results per input beat, in order
    typedef struct packed {
        logic [1:0] count;
        t_result    first;
        t_result    second;
    } t_emit;

    // Magic "IRJC"
    function automatic logic [7:0] magic_byte(input logic [1:0] idx);
        logic [7:0] b;
        case (idx)
            2'd0:    b = 8'h49;
            2'd1:    b = 8'h52;
            2'd2:    b = 8'h4A;
            default: b = 8'h43;
        endcase
        return b;
    endfunction

    // One byte through the reflected CRC-32
    function automatic logic [31:0] crc_byte(input logic [31:0] crc_in,
                                             input logic [7:0]  data);
        logic [31:0] c;
        c = crc_in ^ {24'd0, data};
        for (int i = 0; i < 8; i++) begin
            c = (c >> 1) ^ (CRC_POLY & {32{c[0]}});
        end
        return c;
    endfunction

    // Offset to report width (zero-extend or truncate)
    function automatic logic [OUT_OFF_BITS-1:0] to_out_off(input t_offset off);
        logic [63:0] w;
        w = 64'(off);
        return w[OUT_OFF_BITS-1:0];
    endfunction

endpackage

`default_nettype wire

// File: rtl/core/journal_record_deframer.sv
// ----------------------------------------------------------------------------
// journal_record_deframer
// Checks a journal byte stream record by record and reports accepted
// records and an end-of-file summary.
// ----------------------------------------------------------------------------
// A byte is held in the input register until the result queue has room,
// then parsed; its results are written into the result queue for the sink.
// Throughput: one byte per cycle; the input stalls only while the 4-entry
// result queue lacks room for two results, which takes sink stalls.
// Reset (i_rst_n low, synchronous): parse state, offsets and queue clear;
// expected_version returns to 1. No clearing pass.
`default_nettype none

module journal_record_deframer
    import jrd_pkg::*;
(
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    // byte input channel
    input  wire logic                    i_valid,
    output logic                         o_stall,
    input  wire logic [7:0]              i_data_byte,
    input  wire logic                    i_end_of_file,
    // configuration
    input  wire logic                    i_cfg_we,
    input  wire logic [31:0]             i_cfg_data,
    // result channel
    output logic                         o_valid,
    input  wire logic                    i_stall,
    output logic                         o_kind,
    output logic [63:0]                  o_record_sequence,
    output logic [31:0]                  o_payload_length,
    output logic [OUT_OFF_BITS-1:0]      o_record_offset,
    output logic [OUT_OFF_BITS-1:0]      o_valid_bytes,
    output logic                         o_tail_discarded,
    output logic                         o_last_of_run
);

    logic [31:0] r_exp_version;
    logic        r_in_valid;
    logic [7:0]  r_in_byte;
    logic        r_in_eof;
    logic        accept;
    logic        proc;
    logic        room;
    t_emit       emit;
    t_result     head;

    // Input register handshake
    assign proc    = r_in_valid && room;
    assign o_stall = r_in_valid && !room;
    assign accept  = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (accept) begin
            r_in_valid <= 1'b1;
        end else if (proc) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in_byte <= i_data_byte;
            r_in_eof  <= i_end_of_file;
        end
    end

    // Version register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exp_version <= 32'd1;
        end else if (i_cfg_we) begin
            r_exp_version <= i_cfg_data;
        end
    end

    jrd_parser u_parser (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_proc    (proc),
        .i_byte    (r_in_byte),
        .i_eof     (r_in_eof),
        .i_version (r_exp_version),
        .o_emit    (emit)
    );

    jrd_res_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_emit  (emit),
        .i_stall (i_stall),
        .o_valid (o_valid),
        .o_head  (head),
        .o_room  (room)
    );

    // Result fields
    assign o_kind            = head.kind;
    assign o_record_sequence = head.record_sequence;
    assign o_payload_length  = head.payload_length;
    assign o_record_offset   = head.record_offset;
    assign o_valid_bytes     = head.valid_bytes;
    assign o_tail_discarded  = head.tail_discarded;
    assign o_last_of_run     = head.last_of_run;

endmodule

`default_nettype wire

// File: rtl/core/jrd_parser.sv
// ----------------------------------------------------------------------------
// jrd_parser
// Record parse state: header assembly and checks, payload CRC, offsets.
// Consumes one registered beat per cycle while i_proc is high and emits up to two results.
// ----------------------------------------------------------------------------
`default_nettype none

module jrd_parser
    import jrd_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_proc,
    input  wire logic [7:0]  i_byte,
    input  wire logic        i_eof,
    input  wire logic [31:0] i_version,
    output t_emit            o_emit
);

    localparam logic PH_HEADER  = 1'b0;
    localparam logic PH_PAYLOAD = 1'b1;

    logic        r_phase,     n_phase;
    logic [4:0]  r_hc,        n_hc;
    logic [63:0] r_shift,     n_shift;
    logic [63:0] r_held_seq,  n_held_seq;
    logic [31:0] r_held_len,  n_held_len;
    logic [31:0] r_held_crc,  n_held_crc;
    logic [31:0] r_crc,       n_crc;
    logic [31:0] r_bytes_left, n_bytes_left;
    logic [63:0] r_prev_seq,  n_prev_seq;
    t_offset     r_byte_off,  n_byte_off;
    t_offset     r_start_off, n_start_off;
    logic        r_stopped,   n_stopped;

    logic        rec_hit;
    logic        hc_inc;
    logic        clean;
    t_result     rec;
    t_result     sum;

    // Per-beat parse step
    always_comb begin
        n_phase      = r_phase;
        n_hc         = r_hc;
        n_shift      = r_shift;
        n_held_seq   = r_held_seq;
        n_held_len   = r_held_len;
        n_held_crc   = r_held_crc;
        n_crc        = r_crc;
        n_bytes_left = r_bytes_left;
        n_prev_seq   = r_prev_seq;
        n_start_off  = r_start_off;
        n_stopped    = r_stopped;
        n_byte_off   = r_byte_off + 1'b1;
        rec_hit      = 1'b0;
        hc_inc       = 1'b0;

        if (!r_stopped) begin
            if (r_phase == PH_PAYLOAD && r_bytes_left != 32'd0) begin
                // payload byte: CRC and count down
                n_crc        = crc_byte(r_crc, i_byte);
                n_bytes_left = r_bytes_left - 32'd1;
                if (n_bytes_left == 32'd0) begin
                    if (~n_crc != r_held_crc) begin
                        n_stopped = 1'b1;
                    end else begin
                        rec_hit    = 1'b1;
                        n_prev_seq = r_held_seq;
                        n_phase    = PH_HEADER;
                        n_hc       = 5'd0;
                    end
                end
            end else begin
                // header byte
                if (r_hc == 5'd0) begin
                    n_start_off = r_byte_off;
                end
                n_shift = {i_byte, r_shift[63:8]};
                hc_inc  = 1'b1;
                if (r_hc < HC_MAGIC_END) begin
                    if (i_byte != magic_byte(r_hc[1:0])) begin
                        n_stopped = 1'b1;
                        hc_inc    = 1'b0;
                    end
                end else if (r_hc == HC_VERSION_END) begin
                    if (n_shift[63:32] != i_version) begin
                        n_stopped = 1'b1;
                        hc_inc    = 1'b0;
                    end
                end else if (r_hc == HC_SEQ_END) begin
                    n_held_seq = n_shift;
                end else if (r_hc == HC_LEN_END) begin
                    n_held_len = n_shift[63:32];
                end else if (r_hc == HC_CRC_END) begin
                    hc_inc     = 1'b0;
                    n_held_crc = n_shift[63:32];
                    if (r_held_seq <= r_prev_seq) begin
                        n_stopped = 1'b1;
                    end else if (r_held_len == 32'd0) begin
                        // empty payload: CRC must be zero
                        if (n_shift[63:32] != 32'd0) begin
                            n_stopped = 1'b1;
                        end else begin
                            rec_hit    = 1'b1;
                            n_prev_seq = r_held_seq;
                            n_phase    = PH_HEADER;
                            n_hc       = 5'd0;
                        end
                    end else begin
                        n_phase      = PH_PAYLOAD;
                        n_bytes_left = r_held_len;
                        n_crc        = CRC_INIT;
                        n_hc         = 5'd0;
                    end
                end
                if (hc_inc) begin
                    n_hc = r_hc + 5'd1;
                end
            end
        end

        clean = !n_stopped && n_phase == PH_HEADER && n_hc == 5'd0;

        // results
        rec.kind            = KIND_RECORD;
        rec.record_sequence = r_held_seq;
        rec.payload_length  = r_held_len;
        rec.record_offset   = to_out_off(n_start_off);
        rec.valid_bytes     = '0;
        rec.tail_discarded  = 1'b0;
        rec.last_of_run     = !i_eof;

        sum.kind            = KIND_SUMMARY;
        sum.record_sequence = '0;
        sum.payload_length  = '0;
        sum.record_offset   = '0;
        sum.valid_bytes     = clean ? to_out_off(n_byte_off) : to_out_off(n_start_off);
        sum.tail_discarded  = !clean;
        sum.last_of_run     = 1'b1;

        o_emit.first  = rec_hit ? rec : sum;
        o_emit.second = sum;
        o_emit.count  = i_proc ? ({1'b0, rec_hit} + {1'b0, i_eof}) : 2'd0;

        // end of file: back to the start of a new file
        if (i_eof) begin
            n_phase      = PH_HEADER;
            n_hc         = 5'd0;
            n_shift      = '0;
            n_held_seq   = '0;
            n_held_len   = '0;
            n_held_crc   = '0;
            n_crc        = CRC_INIT;
            n_bytes_left = '0;
            n_prev_seq   = '0;
            n_byte_off   = '0;
            n_start_off  = '0;
            n_stopped    = 1'b0;
        end
    end

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_HEADER;
            r_hc         <= 5'd0;
            r_shift      <= '0;
            r_held_seq   <= '0;
            r_held_len   <= '0;
            r_held_crc   <= '0;
            r_crc        <= CRC_INIT;
            r_bytes_left <= '0;
            r_prev_seq   <= '0;
            r_byte_off   <= '0;
            r_start_off  <= '0;
            r_stopped    <= 1'b0;
        end else if (i_proc) begin
            r_phase      <= n_phase;
            r_hc         <= n_hc;
            r_shift      <= n_shift;
            r_held_seq   <= n_held_seq;
            r_held_len   <= n_held_len;
            r_held_crc   <= n_held_crc;
            r_crc        <= n_crc;
            r_bytes_left <= n_bytes_left;
            r_prev_seq   <= n_prev_seq;
            r_byte_off   <= n_byte_off;
            r_start_off  <= n_start_off;
            r_stopped    <= n_stopped;
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/jrd_res_queue.sv
// ----------------------------------------------------------------------------
// jrd_res_queue
// Small result queue: takes up to two results per cycle, hands out one.
// ----------------------------------------------------------------------------
`default_nettype none

module jrd_res_queue
    import jrd_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  t_emit     i_emit,
    input  wire logic i_stall,
    output logic      o_valid,
    output t_result   o_head,
    output logic      o_room
);

    t_result            r_mem [Q_DEPTH];
    logic [Q_AW-1:0]    r_wr_ptr, n_wr_ptr;
    logic [Q_AW-1:0]    r_rd_ptr, n_rd_ptr;
    logic [Q_AW:0]      r_count,  n_count;
    logic               pop;
    logic [Q_AW-1:0]    wr_next;

    assign o_valid = r_count != '0;
    assign o_head  = r_mem[r_rd_ptr];
    // room for a full two-result beat
    assign o_room  = r_count <= (Q_AW + 1)'(Q_DEPTH - 2);
    assign pop     = o_valid && !i_stall;
    assign wr_next = r_wr_ptr + 1'b1;

    // Pointer and fill bookkeeping
    always_comb begin
        n_wr_ptr = r_wr_ptr + Q_AW'(i_emit.count);
        n_rd_ptr = pop ? r_rd_ptr + 1'b1 : r_rd_ptr;
        n_count  = r_count + (Q_AW + 1)'(i_emit.count) - (Q_AW + 1)'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Entry writes
    always_ff @(posedge i_clk) begin
        if (i_emit.count != 2'd0) begin
            r_mem[r_wr_ptr] <= i_emit.first;
        end
        if (i_emit.count == 2'd2) begin
            r_mem[wr_next] <= i_emit.second;
        end
    end

endmodule

`default_nettype wire

// File: verif/jrd_check_pkg.sv
// ----------------------------------------------------------------------------
// jrd_check_pkg
// Result prediction and checking for the journal record deframer bench.
// The scoreboard parses the same byte stream as the block, beat by beat,
// queues the record and summary results each byte should produce, and
// compares every delivered result against the oldest one queued.
// ----------------------------------------------------------------------------
package jrd_check_pkg;

    import jrd_pkg::*;

    // "IRJC", first byte in the low lane
    localparam logic [31:0] JOURNAL_MAGIC = 32'h434A_5249;
    localparam int unsigned MAX_REPORTED  = 10;

    typedef enum logic {AT_HEADER, AT_PAYLOAD} t_parse_at;

    // Reflected CRC-32, one byte
    function automatic logic [31:0] crc32_step(input logic [31:0] crc,
                                               input logic [7:0]  b);
        logic [31:0] c;
        c = crc ^ {24'd0, b};
        repeat (8) c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        return c;
    endfunction

    class record_scoreboard;
        t_result     expected_reports[$];
        t_result     fresh[$];
        int unsigned errors;
        logic [31:0] version;

        // parser state of the current file
        t_parse_at   at;
        logic [4:0]  hdr_pos;
        logic [63:0] shifter;
        logic [63:0] seq_hold;
        logic [63:0] prev_seq;
        logic [31:0] len_hold;
        logic [31:0] crc_hold;
        logic [31:0] crc_run;
        logic [31:0] left;
        t_offset     pos;
        t_offset     rec_start;
        bit          halted;

        function void power_on();
            version = 32'd1;
            errors  = 0;
            expected_reports.delete();
            restart_file();
        endfunction

        function void restart_file();
            at        = AT_HEADER;
            hdr_pos   = '0;
            shifter   = '0;
            seq_hold  = '0;
            prev_seq  = '0;
            len_hold  = '0;
            crc_hold  = '0;
            crc_run   = CRC_INIT;
            left      = '0;
            pos       = '0;
            rec_start = '0;
            halted    = 1'b0;
        endfunction

        function void set_version(input logic [31:0] v);
            version = v;
        endfunction

        function int unsigned pending();
            return expected_reports.size();
        endfunction

        function void note_error(input string msg);
            errors++;
            if (errors <= MAX_REPORTED)
                $display("mismatch: %s", msg);
        endfunction

        // Append to the results of the current beat
        function void add_fresh(input t_result r);
            fresh.insert(fresh.size(), r);
        endfunction

        function void post_record();
            t_result r;
            r = '0;
            r.kind            = KIND_RECORD;
            r.record_sequence = seq_hold;
            r.payload_length  = len_hold;
            r.record_offset   = to_out_off(rec_start);
            add_fresh(r);
            prev_seq = seq_hold;
            at       = AT_HEADER;
            hdr_pos  = '0;
        endfunction

        // Header bytes shift in from the top; a field is complete at its last byte
        function void header_byte(input logic [7:0] b);
            if (hdr_pos == 0)
                rec_start = pos;
            shifter = {b, shifter[63:8]};
            if (hdr_pos < HC_MAGIC_END) begin
                if (b != JOURNAL_MAGIC[8*hdr_pos +: 8]) begin
                    halted = 1'b1;
                    return;
                end
            end else if (hdr_pos == HC_VERSION_END) begin
                if (shifter[63:32] != version) begin
                    halted = 1'b1;
                    return;
                end
            end else if (hdr_pos == HC_SEQ_END) begin
                seq_hold = shifter;
            end else if (hdr_pos == HC_LEN_END) begin
                len_hold = shifter[63:32];
            end else if (hdr_pos == HC_CRC_END) begin
                crc_hold = shifter[63:32];
                if (seq_hold <= prev_seq) begin
                    halted = 1'b1;
                end else if (len_hold == 0) begin
                    // empty payload: judged right here, its CRC must be zero
                    if (crc_hold != 0)
                        halted = 1'b1;
                    else
                        post_record();
                end else begin
                    at      = AT_PAYLOAD;
                    left    = len_hold;
                    crc_run = CRC_INIT;
                    hdr_pos = '0;
                end
                return;
            end
            hdr_pos = hdr_pos + 5'd1;
        endfunction

        function void payload_byte(input logic [7:0] b);
            crc_run = crc32_step(crc_run, b);
            left    = left - 32'd1;
            if (left != 0)
                return;
            if (~crc_run != crc_hold)
                halted = 1'b1;
            else
                post_record();
        endfunction

        // One accepted input beat
        function void take_byte(input logic [7:0] b, input logic eof);
            t_result r;
            logic    clean;
            fresh.delete();
            if (!halted) begin
                if (at == AT_PAYLOAD && left != 0)
                    payload_byte(b);
                else
                    header_byte(b);
            end
            pos = pos + 1'b1;

            // end of file: summary after any record, then a fresh file
            if (eof) begin
                clean = !halted && at == AT_HEADER && hdr_pos == 0;
                r = '0;
                r.kind           = KIND_SUMMARY;
                r.valid_bytes    = clean ? to_out_off(pos) : to_out_off(rec_start);
                r.tail_discarded = !clean;
                add_fresh(r);
                restart_file();
            end

            if (fresh.size() != 0) begin
                r = fresh.pop_back();
                r.last_of_run = 1'b1;
                add_fresh(r);
            end
            while (fresh.size() != 0)
                expected_reports.insert(expected_reports.size(), fresh.pop_front());
        endfunction

        function void field(input string name, input logic [63:0] want,
                            input logic [63:0] got);
            if (got !== want)
                note_error($sformatf("%s expected 0x%0h, got 0x%0h", name, want, got));
        endfunction

        // One delivered result beat
        function void check_report(input t_result got);
            t_result want;
            if (expected_reports.size() == 0) begin
                note_error($sformatf("unexpected result, kind %0d seq 0x%0h",
                                     got.kind, got.record_sequence));
                return;
            end
            want = expected_reports.pop_front();
            field("kind", want.kind, got.kind);
            field("record_sequence", want.record_sequence, got.record_sequence);
            field("payload_length", want.payload_length, got.payload_length);
            field("record_offset", want.record_offset, got.record_offset);
            field("valid_bytes", want.valid_bytes, got.valid_bytes);
            field("tail_discarded", want.tail_discarded, got.tail_discarded);
            field("last_of_run", want.last_of_run, got.last_of_run);
        endfunction

        function void close_out();
            while (expected_reports.size() != 0) begin
                note_error($sformatf("missing result, kind %0d",
                                     expected_reports[0].kind));
                void'(expected_reports.pop_front());
            end
        endfunction
    endclass

endpackage

// File: verif/tb.sv
// ----------------------------------------------------------------------------
// tb
// Bench for the journal record deframer. Journal files are assembled from
// well-formed records with random content, broken records, cut files and
// noise, and streamed in with random source gaps and sink stalls under
// several expected versions. Every result is checked by the scoreboard.
// ----------------------------------------------------------------------------
module tb;

    timeunit 1ns;
    timeprecision 1ps;

    import jrd_pkg::*;
    import jrd_check_pkg::*;

    localparam int unsigned PHASE_BYTES    = 190;
    localparam int unsigned HOLD_CYCLES    = 300;
    localparam int unsigned WATCHDOG_LIMIT = 4000;

    typedef enum {FLAW_NONE, FLAW_MAGIC, FLAW_VERSION, FLAW_SEQ, FLAW_CRC} t_flaw;

    logic                    i_clk;
    logic                    i_rst_n;
    logic                    i_valid;
    logic                    o_stall;
    logic [7:0]              i_data_byte;
    logic                    i_end_of_file;
    logic                    i_cfg_we;
    logic [31:0]             i_cfg_data;
    logic                    o_valid;
    logic                    i_stall;
    logic                    o_kind;
    logic [63:0]             o_record_sequence;
    logic [31:0]             o_payload_length;
    logic [OUT_OFF_BITS-1:0] o_record_offset;
    logic [OUT_OFF_BITS-1:0] o_valid_bytes;
    logic                    o_tail_discarded;
    logic                    o_last_of_run;

    record_scoreboard sb;
    logic [7:0]       file_q[$];
    logic [31:0]      cur_version;
    int unsigned      bytes_sent;
    int unsigned      src_idle_pct;
    int unsigned      snk_stall_pct;
    bit               hold_pending;
    int unsigned      hold_left;

    journal_record_deframer u_top (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_stall           (o_stall),
        .i_data_byte       (i_data_byte),
        .i_end_of_file     (i_end_of_file),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_data        (i_cfg_data),
        .o_valid           (o_valid),
        .i_stall           (i_stall),
        .o_kind            (o_kind),
        .o_record_sequence (o_record_sequence),
        .o_payload_length  (o_payload_length),
        .o_record_offset   (o_record_offset),
        .o_valid_bytes     (o_valid_bytes),
        .o_tail_discarded  (o_tail_discarded),
        .o_last_of_run     (o_last_of_run)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Sink: random stalls, or a long counted hold-off when requested
    always @(negedge i_clk) begin
        if (hold_pending) begin
            hold_pending = 1'b0;
            hold_left    = HOLD_CYCLES;
        end
        if (hold_left != 0) begin
            hold_left--;
            i_stall = 1'b1;
        end else begin
            i_stall = (snk_stall_pct != 0) && ($urandom_range(99) < snk_stall_pct);
        end
    end

    // Result monitor
    always @(posedge i_clk) begin : result_mon
        t_result got;
        if (i_rst_n && o_valid === 1'b1 && !i_stall) begin
            got.kind            = o_kind;
            got.record_sequence = o_record_sequence;
            got.payload_length  = o_payload_length;
            got.record_offset   = o_record_offset;
            got.valid_bytes     = o_valid_bytes;
            got.tail_discarded  = o_tail_discarded;
            got.last_of_run     = o_last_of_run;
            sb.check_report(got);
        end
    end

    // Watchdog: cycles with no beat on either channel
    initial begin : watchdog
        int unsigned quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((i_valid && !o_stall) || (o_valid === 1'b1 && !i_stall))
                quiet = 0;
            else
                quiet++;
        end
        $display("== FAIL ==");
        $finish;
    end

    // Append one byte to the file being assembled
    task automatic append_byte(input logic [7:0] b);
        file_q.insert(file_q.size(), b);
    endtask

    // Called at a falling edge; returns at the falling edge after the beat
    task automatic send_byte(input logic [7:0] b, input logic eof);
        while (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct) begin
            i_valid = 1'b0;
            @(negedge i_clk);
        end
        i_valid       = 1'b1;
        i_data_byte   = b;
        i_end_of_file = eof;
        do @(posedge i_clk); while (o_stall);
        sb.take_byte(b, eof);
        bytes_sent++;
        @(negedge i_clk);
    endtask

    // Stream the first cut bytes of the assembled file, end flag on the last
    task automatic send_file(input int unsigned cut);
        int unsigned k;
        for (k = 0; k < cut; k++)
            send_byte(file_q[k], k == cut - 1);
        file_q.delete();
        i_valid = 1'b0;
    endtask

    task automatic push_le(input logic [63:0] v, input int unsigned n);
        int unsigned k;
        for (k = 0; k < n; k++)
            append_byte(v[8*k +: 8]);
    endtask

    // Header plus nbody payload bytes; a magic, version or CRC flaw corrupts that header field
    task automatic add_record(input logic [63:0] seq, input logic [31:0] len,
                              input int unsigned nbody, input t_flaw flaw);
        logic [7:0]  body[$];
        logic [31:0] crc;
        logic [31:0] ver;
        int unsigned k;
        int unsigned bad;
        crc = CRC_INIT;
        for (k = 0; k < nbody; k++) begin
            body.insert(body.size(), 8'($urandom));
            crc = crc32_step(crc, body[k]);
        end
        crc = ~crc;
        if (flaw == FLAW_CRC)
            crc = crc ^ (32'd1 << $urandom_range(31));
        ver = cur_version;
        if (flaw == FLAW_VERSION)
            ver = ver ^ (32'd1 << $urandom_range(31));
        bad = (flaw == FLAW_MAGIC) ? $urandom_range(3) : 4;
        for (k = 0; k < 4; k++)
            append_byte(JOURNAL_MAGIC[8*k +: 8] ^
                        ((k == bad) ? 8'($urandom_range(1, 255)) : 8'd0));
        push_le(64'(ver), 4);
        push_le(seq, 8);
        push_le(64'(len), 4);
        push_le(64'(crc), 4);
        for (k = 0; k < nbody; k++)
            append_byte(body[k]);
    endtask

    function automatic logic [63:0] next_seq(input logic [63:0] prev);
        logic [63:0] step;
        case ($urandom_range(9))
            0:       step = {$urandom, $urandom};
            1:       step = 64'($urandom);
            default: step = 64'($urandom_range(1, 4));
        endcase
        return prev + step;
    endfunction

    // Mostly valid record chains; some broken, cut, padded or pure noise
    task automatic random_file();
        int unsigned nrec;
        int unsigned r;
        int unsigned len;
        int unsigned cut;
        logic [63:0] seq;
        t_flaw       flaw;
        seq = '0;
        if ($urandom_range(99) < 6) begin
            repeat ($urandom_range(1, 30)) append_byte(8'($urandom));
        end else begin
            nrec = $urandom_range(1, 4);
            for (r = 0; r < nrec; r++) begin
                flaw = FLAW_NONE;
                if (r == nrec - 1 && $urandom_range(99) < 25)
                    flaw = t_flaw'($urandom_range(1, 4));
                len = ($urandom_range(99) < 5) ? $urandom_range(40, 160)
                                               : $urandom_range(0, 12);
                if (flaw == FLAW_SEQ)
                    seq = ($urandom_range(1) == 0) ? seq : (seq >> 1);
                else
                    seq = next_seq(seq);
                add_record(seq, len, len, flaw);
            end
            if ($urandom_range(99) < 15)
                repeat ($urandom_range(1, 8)) append_byte(8'($urandom));
        end
        cut = file_q.size();
        if ($urandom_range(99) < 12)
            cut = $urandom_range(1, cut);
        send_file(cut);
    endtask

    task automatic pick_mode(input int unsigned mode);
        case (mode)
            0:       begin src_idle_pct = 0;  snk_stall_pct = 0;  end
            1:       begin src_idle_pct = 51; snk_stall_pct = 0;  end
            2:       begin src_idle_pct = 0;  snk_stall_pct = 51; end
            default: begin src_idle_pct = 13; snk_stall_pct = 13; end
        endcase
    endtask

    // Wait for every expected result, then let the pipeline settle
    task automatic drain();
        i_valid = 1'b0;
        while (sb.pending() != 0)
            @(negedge i_clk);
        repeat (6) @(negedge i_clk);
    endtask

    task automatic write_version(input logic [31:0] v);
        i_cfg_we   = 1'b1;
        i_cfg_data = v;
        @(negedge i_clk);
        i_cfg_we   = 1'b0;
        sb.set_version(v);
        cur_version = v;
    endtask

    initial begin
        int unsigned ph;
        int unsigned start;
        i_clk         = 1'b0;
        i_rst_n       = 1'b0;
        i_valid       = 1'b0;
        i_data_byte   = 8'd0;
        i_end_of_file = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_data    = 32'd0;
        i_stall       = 1'b0;
        hold_pending  = 1'b0;
        hold_left     = 0;
        bytes_sent    = 0;
        cur_version   = 32'd1;
        pick_mode(0);
        sb = new;
        sb.power_on();

        repeat (6) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed files, reset version
        // empty record whose last header byte also ends the file
        add_record(64'd1, 32'd0, 0, FLAW_NONE);
        send_file(file_q.size());
        // third record is not above the all-ones sequence before it
        add_record(64'd2, 32'd3, 3, FLAW_NONE);
        add_record('1, 32'd1, 1, FLAW_NONE);
        add_record(64'd5, 32'd0, 0, FLAW_NONE);
        send_file(file_q.size());
        // one-byte files: a partial magic, then a bad first byte
        append_byte(8'h49);
        send_file(1);
        append_byte(8'hFF);
        send_file(1);
        // empty payload with nonzero CRC, then ignored bytes
        add_record(64'd7, 32'd0, 0, FLAW_CRC);
        append_byte(8'h00);
        append_byte(8'hFF);
        append_byte(8'h49);
        send_file(file_q.size());
        add_record(64'd3, 32'd2, 2, FLAW_VERSION);
        send_file(file_q.size());
        // repeated sequence
        add_record(64'd9, 32'd4, 4, FLAW_NONE);
        add_record(64'd9, 32'd4, 4, FLAW_NONE);
        send_file(file_q.size());
        add_record(64'd1, 32'd5, 5, FLAW_CRC);
        send_file(file_q.size());
        // end of file inside a payload
        add_record(64'd4, 32'd6, 6, FLAW_NONE);
        send_file(27);
        // largest declared length, file cut short
        add_record(64'd1, 32'hFFFF_FFFF, 2, FLAW_NONE);
        send_file(file_q.size());
        // one header byte past a clean record
        add_record(64'd6, 32'd1, 1, FLAW_NONE);
        append_byte(8'h49);
        send_file(file_q.size());
        add_record(64'd1, 32'd0, 0, FLAW_MAGIC);
        send_file(file_q.size());
        add_record(64'd1, 32'd2, 2, FLAW_NONE);
        add_record(64'd2, 32'd0, 0, FLAW_NONE);
        send_file(file_q.size());

        // Random phases across versions and idling patterns
        for (ph = 1; ph <= 5; ph++) begin
            drain();
            case (ph)
                1:       write_version(32'd0);
                2:       write_version(32'hFFFF_FFFF);
                4:       write_version(32'd1);
                default: write_version($urandom);
            endcase
            pick_mode((ph == 5) ? 0 : ph % 4);
            // long sink hold-off while the source keeps streaming
            if (ph == 4)
                hold_pending = 1'b1;
            start = bytes_sent;
            while (bytes_sent - start < PHASE_BYTES) begin
                if (ph == 5)
                    pick_mode($urandom_range(3));
                random_file();
            end
        end

        drain();
        sb.close_out();
        if (sb.errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
